>>> sv/aart_pkg.sv
// ----------------------------------------------------------------------------
// aart_pkg
// Shared types and constants for the address register tracker: decode
// masks and patterns, register indexes and the execute result record.
// ----------------------------------------------------------------------------
package aart_pkg;

  localparam int XLEN      = 64;
  localparam int INSN_W    = 32;
  localparam int REG_COUNT = 32;
  localparam int REG_IDX_W = $clog2(REG_COUNT);
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT = 2'd2;

  // Mode codes
  localparam logic MODE_CALC = 1'b0;
  localparam logic MODE_XREF = 1'b1;

  // Decode masks and patterns
  localparam logic [INSN_W-1:0] MASK_ADR      = 32'h9F00_0000;
  localparam logic [INSN_W-1:0] PAT_ADRP      = 32'h9000_0000;
  localparam logic [INSN_W-1:0] PAT_ADR       = 32'h1000_0000;
  localparam logic [INSN_W-1:0] MASK_OPC8     = 32'hFF00_0000;
  localparam logic [INSN_W-1:0] PAT_ADD_IMM   = 32'h9100_0000;
  localparam logic [INSN_W-1:0] PAT_LDR_LIT   = 32'h5800_0000;
  localparam logic [INSN_W-1:0] MASK_LDST     = 32'hF9C0_0000;
  localparam logic [INSN_W-1:0] PAT_LDR_UOFF  = 32'hF940_0000;
  localparam logic [INSN_W-1:0] PAT_STR_UOFF  = 32'hF900_0000;
  localparam logic [INSN_W-1:0] MASK_LIT_IMM  = 32'h00FF_FFE0;

  // ADD immediate shift codes
  localparam logic [1:0] SH_NONE = 2'b00;
  localparam logic [1:0] SH_12   = 2'b01;

  // Result of executing one instruction against the register file
  typedef struct packed {
    logic                 wr_en;
    logic [REG_IDX_W-1:0] wr_idx;
    logic [XLEN-1:0]      value;
    logic                 skipped;
  } exec_t;

endpackage

>>> sv/arm64_address_register_tracker.sv
// ----------------------------------------------------------------------------
// arm64_address_register_tracker
// Follows address-forming ARM64 instructions over a 32-entry register file.
// ----------------------------------------------------------------------------
// Each instruction word with its address enters an input register; from
// there it is decoded, its source register read, one 64-bit add done and
// the register file and result register updated together, so one
// instruction is taken every cycle while the output is not stalled. The
// register file lives in flip-flops with a valid bit per entry; reset and
// a restart flag clear the valid bits at once, so no clearing pass is
// needed. A result carries the match flag in bit 0 of m_tdata and the
// selected register's value above it. Configuration is written through
// the cfg port, which is always ready, and must only change while no
// instruction is in flight.
module arm64_address_register_tracker (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [aart_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [aart_pkg::XLEN-1:0]        cfg_data,
  // Instruction stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [95:0]                      s_tdata,  // instruction[31:0], pc[95:32]
  input  logic                             s_tuser,  // restart
  // Result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [71:0]                      m_tdata   // match[0], selected_value[64:1], zero
);
  import aart_pkg::*;

  // Configuration registers
  logic                 mode;
  logic [XLEN-1:0]      target;
  logic [REG_IDX_W-1:0] report_register;

  // Input stage
  logic                 in_valid;
  logic [INSN_W-1:0]    in_insn;
  logic [XLEN-1:0]      in_pc;
  logic                 in_restart;

  // Register file
  logic [XLEN-1:0]      rf_data [REG_COUNT];
  logic [REG_COUNT-1:0] rf_valid;

  // Result register
  logic                 out_valid;
  logic                 out_match;
  logic [XLEN-1:0]      out_value;

  logic                 advance;
  logic [XLEN-1:0]      rn_value;
  logic [XLEN-1:0]      rd_after;
  logic [XLEN-1:0]      sel_after;
  exec_t                ex;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {7'd0, out_value, out_match};

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_CALC;
      target          <= '0;
      report_register <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE:   mode            <= cfg_data[0];
        CFG_TARGET: target          <= cfg_data;
        CFG_REPORT: report_register <= cfg_data[REG_IDX_W-1:0];
        default:    mode            <= mode;
      endcase
    end
  end

  // Capture the incoming instruction
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_insn    <= s_tdata[31:0];
      in_pc      <= s_tdata[95:32];
      in_restart <= s_tuser;
    end
  end

  // Read the base register; a restart hides every entry
  function automatic logic [XLEN-1:0] rf_read(input logic [REG_IDX_W-1:0] idx,
                                                input logic clear,
                                                input logic [REG_COUNT-1:0] vld,
                                                input logic [XLEN-1:0] val);
    rf_read = (!clear && vld[idx]) ? val : '0;
  endfunction

  assign rn_value = rf_read(in_insn[9:5], in_restart, rf_valid, rf_data[in_insn[9:5]]);

  aart_exec u_exec (
    .instruction (in_insn),
    .pc          (in_pc),
    .mode        (mode),
    .rn_value    (rn_value),
    .result      (ex)
  );

  // Forward the fresh write into the post-update reads
  assign rd_after = (ex.wr_en && ex.wr_idx == in_insn[4:0]) ? ex.value :
                    rf_read(in_insn[4:0], in_restart, rf_valid, rf_data[in_insn[4:0]]);
  assign sel_after = (ex.wr_en && ex.wr_idx == report_register) ? ex.value :
                     rf_read(report_register, in_restart, rf_valid,
                             rf_data[report_register]);

  // Update valid bits; restart drops every entry before the write
  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid <= '0;
    end else if (advance) begin
      if (ex.wr_en) begin
        rf_valid <= (in_restart ? '0 : rf_valid) | (REG_COUNT'(1) << ex.wr_idx);
      end else if (in_restart) begin
        rf_valid <= '0;
      end
    end
  end

  // Write register data
  always_ff @(posedge clk) begin
    if (advance && ex.wr_en) begin
      rf_data[ex.wr_idx] <= ex.value;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_match <= !ex.skipped && (rd_after == target);
      out_value <= sel_after;
    end
  end

endmodule

>>> sv/aart_exec.sv
// ----------------------------------------------------------------------------
// aart_exec
// Decodes one instruction word and forms the value written back to the
// tracked register file through a single shared 64-bit adder.
// ----------------------------------------------------------------------------
module aart_exec (
  input  logic [aart_pkg::INSN_W-1:0] instruction,
  input  logic [aart_pkg::XLEN-1:0]   pc,
  input  logic                        mode,
  input  logic [aart_pkg::XLEN-1:0]   rn_value,
  output aart_pkg::exec_t             result
);
  import aart_pkg::*;

  logic [REG_IDX_W-1:0] rd;
  logic [REG_IDX_W-1:0] rn;
  logic [11:0]          imm12;
  logic [1:0]           sh;
  logic [20:0]          imm21;
  logic [XLEN-1:0]      imm21_sext;
  logic [XLEN-1:0]      pc_word;
  logic [XLEN-1:0]      opa;
  logic [XLEN-1:0]      opb;

  assign rd         = instruction[4:0];
  assign rn         = instruction[9:5];
  assign imm12      = instruction[21:10];
  assign sh         = instruction[23:22];
  assign imm21      = {instruction[23:5], instruction[30:29]};
  assign imm21_sext = {{(XLEN-21){imm21[20]}}, imm21};
  assign pc_word    = {pc[XLEN-1:2], 2'b00};

  // Pick operands and destination by decode priority
  always_comb begin
    opa            = '0;
    opb            = '0;
    result.wr_en   = 1'b0;
    result.wr_idx  = rd;
    result.skipped = 1'b0;
    priority if ((instruction & MASK_ADR) == PAT_ADRP) begin
      opa          = {imm21_sext[XLEN-13:0], 12'h000};
      opb          = {pc_word[XLEN-1:12], 12'h000};
      result.wr_en = 1'b1;
    end else if ((instruction & MASK_OPC8) == PAT_ADD_IMM) begin
      opa = rn_value;
      if (sh == SH_NONE) begin
        opb          = {{(XLEN-12){1'b0}}, imm12};
        result.wr_en = 1'b1;
      end else if (sh == SH_12) begin
        opb          = {{(XLEN-24){1'b0}}, imm12, 12'h000};
        result.wr_en = 1'b1;
      end else begin
        result.skipped = 1'b1;
      end
    end else if ((instruction & MASK_LDST) == PAT_LDR_UOFF) begin
      opa = rn_value;
      opb = {{(XLEN-15){1'b0}}, imm12, 3'b000};
      if (imm12 == '0) begin
        result.skipped = 1'b1;
      end else begin
        result.wr_en = 1'b1;
      end
    end else if (mode == MODE_CALC && (instruction & MASK_LDST) == PAT_STR_UOFF) begin
      opa           = rn_value;
      opb           = {{(XLEN-15){1'b0}}, imm12, 3'b000};
      result.wr_idx = rn;
      if (imm12 == '0) begin
        result.skipped = 1'b1;
      end else begin
        result.wr_en = 1'b1;
      end
    end else if ((instruction & MASK_ADR) == PAT_ADR) begin
      opa          = imm21_sext;
      opb          = pc_word;
      result.wr_en = 1'b1;
    end else if ((instruction & MASK_OPC8) == PAT_LDR_LIT) begin
      opa          = {{(XLEN-21){1'b0}}, instruction[23:5], 2'b00};
      opb          = pc_word;
      result.wr_en = 1'b1;
    end else begin
      result.wr_en = 1'b0;
    end
    // Shared wrapping adder
    result.value = opa + opb;
  end

endmodule

>>> sv/aart_checker.sv
// ----------------------------------------------------------------------------
// aart_checker
// Port-level checks on the address register tracker, bound to the top level.
// ----------------------------------------------------------------------------
module aart_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata
);

  // Drop any result on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Accept input whenever the result register is empty
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // Keep padding bits clear
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[71:65] == 7'd0)
    else $error("nonzero padding in result");

endmodule

bind arm64_address_register_tracker aart_checker u_aart_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
